@@ hw/rtl/led_matrix_frame_refresh_top_macros.svh @@
// Assertion helpers used by the RTL file lmfr_back.sv.
// Each macro expects signals named clk and rst in the using module.
`ifndef LED_MATRIX_FRAME_REFRESH_TOP_MACROS_SVH
`define LED_MATRIX_FRAME_REFRESH_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lmfr_pkg.sv @@
`timescale 1ns / 1ps
package lmfr_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_PIXEL  = 3'd1;
  localparam logic [2:0] CMD_WRROW  = 3'd2;
  localparam logic [2:0] CMD_RDROW  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_ENABLE = 3'd5;
  localparam logic [2:0] CMD_BRIGHT = 3'd6;

  // Register indexes on the configuration port
  localparam logic REG_REFRESH = 1'b0;
  localparam logic REG_ADDR    = 1'b1;

  // Reset values
  localparam logic [9:0] REFRESH_RESET = 10'd20;
  localparam logic [6:0] ADDR_RESET    = 7'd113;
  localparam logic [3:0] BRIGHT_RESET  = 4'd10;

  // Driver bytes
  localparam logic [7:0] BYTE_OSC_ON    = 8'h21;
  localparam logic [7:0] BYTE_DIM       = 8'hE0;
  localparam logic [7:0] BYTE_DISP_ON   = 8'h81;
  localparam logic [7:0] BYTE_DISP_OFF  = 8'h80;
  localparam logic [7:0] BYTE_FRAME_CMD = 8'h00;

  // Result kinds
  localparam logic KIND_BUS = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_PIXEL,
    OP_WRROW,
    OP_RDROW,
    OP_CLEAR,
    OP_ENABLE,
    OP_BRIGHT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       eye;
    logic [2:0] row;
    logic       row_ok;
    logic [2:0] col;
    logic       pixel_on;
    logic [7:0] row_value;
    logic       enable;
    logic [3:0] brightness;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] target_address;
    logic [7:0] data_byte;
    logic       transfer_end;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ONE,
    B_ENABLE,
    B_FRAME
  } bstate_t;

endpackage

@@ hw/rtl/led_matrix_frame_refresh_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     push / full               cmd eye row col pixel_on row_value enable brightness
// result    empty / pop               kind target_address data_byte transfer_end last
// config    psel penable pwrite paddr pwdata prdata pready (2 regs at 0x0, 0x4)
//
// A command is written into the two-entry front queue and is taken by the back
// sequencer once it is idle; each result then passes through the one-deep output
// register. A due, dirty tick sends the frame command byte and then the row bytes,
// an enable the oscillator, dimming and display-on bytes.
// Synchronous rst clears both frames, the flags and the queues; registers
// return to refresh 20 and address 113. full is high while both queue entries
// are held, as when the back part is busy or stalls on pop.
module led_matrix_frame_refresh_top
  import lmfr_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd,
  input  logic        eye,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic        pixel_on,
  input  logic [7:0]  row_value,
  input  logic        enable,
  input  logic [3:0]  brightness,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [6:0]  target_address,
  output logic [7:0]  data_byte,
  output logic        transfer_end,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] refresh_ms;
  logic [6:0] device_address;
  logic       cfg_wr;
  logic       q_valid;
  cmd_t       q_data;
  logic       q_take;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_ms     <= REFRESH_RESET;
      device_address <= ADDR_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_REFRESH: refresh_ms     <= pwdata[9:0];
        REG_ADDR:    device_address <= pwdata[6:0];
        default:     refresh_ms     <= refresh_ms;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      case (paddr[2])
        REG_REFRESH: prdata = {22'd0, refresh_ms};
        REG_ADDR:    prdata = {25'd0, device_address};
        default:     prdata = 32'd0;
      endcase
    end
  end

  lmfr_front #(
    .ROWS(ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .eye       (eye),
    .row       (row),
    .col       (col),
    .pixel_on  (pixel_on),
    .row_value (row_value),
    .enable    (enable),
    .brightness(brightness),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_take    (q_take)
  );

  lmfr_back #(
    .ROWS(ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_take        (q_take),
    .refresh_ms    (refresh_ms),
    .device_address(device_address),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .target_address(target_address),
    .data_byte     (data_byte),
    .transfer_end  (transfer_end),
    .last          (last)
  );

endmodule

@@ hw/rtl/lmfr_front.sv @@
`timescale 1ns / 1ps
module lmfr_front
  import lmfr_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] cmd,
  input  logic       eye,
  input  logic [2:0] row,
  input  logic [2:0] col,
  input  logic       pixel_on,
  input  logic [7:0] row_value,
  input  logic       enable,
  input  logic [3:0] brightness,
  output logic       q_valid,
  output cmd_t       q_data,
  input  logic       q_take
);

  cmd_t       ent [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  cmd_t       cls;
  logic       known;
  logic       accept;
  logic       wr_en;

  // Classify the item: decode the op and check the row range up front
  always_comb begin
    known          = 1'b1;
    cls.op         = OP_TICK;
    cls.eye        = eye;
    cls.row        = row;
    cls.row_ok     = ({1'b0, row} < 4'(ROWS));
    cls.col        = col;
    cls.pixel_on   = pixel_on;
    cls.row_value  = row_value;
    cls.enable     = enable;
    cls.brightness = brightness;
    case (cmd)
      CMD_TICK:   cls.op = OP_TICK;
      CMD_PIXEL:  cls.op = OP_PIXEL;
      CMD_WRROW:  cls.op = OP_WRROW;
      CMD_RDROW:  cls.op = OP_RDROW;
      CMD_CLEAR:  cls.op = OP_CLEAR;
      CMD_ENABLE: cls.op = OP_ENABLE;
      CMD_BRIGHT: cls.op = OP_BRIGHT;
      default:    known  = 1'b0;
    endcase
  end

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  // drop unused codes here: they have no effect
  assign wr_en   = accept && known;
  assign q_valid = (count != 2'd0);
  assign q_data  = ent[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !(q_take && q_valid)) begin
      count_next = count + 2'd1;
    end else if (!wr_en && q_take && q_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent[wr_ptr] <= cls;
    end
  end

endmodule

@@ hw/rtl/lmfr_back.sv @@
`timescale 1ns / 1ps
`include "led_matrix_frame_refresh_top_macros.svh"
module lmfr_back
  import lmfr_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_take,
  input  logic [9:0] refresh_ms,
  input  logic [6:0] device_address,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [6:0] target_address,
  output logic [7:0] data_byte,
  output logic       transfer_end,
  output logic       last
);

  logic [7:0] frame_rows [16];
  logic       dirty_flag;
  logic       enabled_flag;
  logic       bus_ready;
  logic [3:0] brightness_level;
  logic [9:0] refresh_countdown;
  bstate_t    state;
  bstate_t    state_next;
  logic [2:0] step;
  logic       hdr;
  logic       half;
  logic       one_kind;
  logic [7:0] one_data;
  res_t       out_q;
  logic       out_valid;
  res_t       res_next;
  logic       load;
  logic       out_free;
  logic [3:0] cidx;
  logic [7:0] pmask;

  assign out_free = !out_valid || pop;
  assign cidx     = {q_data.eye, q_data.row};
  assign pmask    = 8'b1 << q_data.col;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            OP_TICK: begin
              if (enabled_flag && refresh_countdown == 10'd0 && dirty_flag) begin
                state_next = B_FRAME;
              end
            end
            OP_RDROW:  state_next = B_ONE;
            OP_ENABLE: begin
              if (q_data.enable) begin
                state_next = B_ENABLE;
              end else if (bus_ready) begin
                state_next = B_ONE;
              end
            end
            OP_BRIGHT: begin
              if (enabled_flag) begin
                state_next = B_ONE;
              end
            end
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_ONE: begin
        if (load) begin
          state_next = B_IDLE;
        end
      end
      B_ENABLE, B_FRAME: begin
        if (load && res_next.last) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_take   = 1'b0;
    load     = 1'b0;
    res_next = '0;
    case (state)
      B_IDLE: q_take = q_valid;
      B_ONE: begin
        load                    = out_free;
        res_next.kind           = one_kind;
        res_next.target_address = (one_kind == KIND_ROW) ? 7'd0 : device_address;
        res_next.data_byte      = one_data;
        res_next.transfer_end   = (one_kind == KIND_BUS);
        res_next.last           = 1'b1;
      end
      B_ENABLE: begin
        load                    = out_free;
        res_next.kind           = KIND_BUS;
        res_next.target_address = device_address;
        res_next.transfer_end   = 1'b1;
        res_next.last           = (step == 3'd2);
        case (step)
          3'd0:    res_next.data_byte = BYTE_OSC_ON;
          3'd1:    res_next.data_byte = BYTE_DIM | {4'd0, brightness_level};
          default: res_next.data_byte = BYTE_DISP_ON;
        endcase
      end
      B_FRAME: begin
        load                    = out_free;
        res_next.kind           = KIND_BUS;
        res_next.target_address = device_address;
        res_next.data_byte      = hdr ? BYTE_FRAME_CMD : frame_rows[{half, step}];
        res_next.transfer_end   = !hdr && half && (step == 3'(ROWS - 1));
        res_next.last           = res_next.transfer_end;
      end
      default: q_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= B_IDLE;
      out_valid         <= 1'b0;
      dirty_flag        <= 1'b0;
      enabled_flag      <= 1'b0;
      bus_ready         <= 1'b0;
      brightness_level  <= BRIGHT_RESET;
      refresh_countdown <= 10'd0;
      for (int i = 0; i < 16; i++) begin
        frame_rows[i] <= 8'd0;
      end
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !pop);
      if (q_take) begin
        case (q_data.op)
          OP_TICK: begin
            if (enabled_flag) begin
              if (refresh_countdown != 10'd0) begin
                refresh_countdown <= refresh_countdown - 10'd1;
              end else begin
                refresh_countdown <= (refresh_ms == 10'd0) ? 10'd0 : refresh_ms - 10'd1;
                if (dirty_flag) begin
                  dirty_flag <= 1'b0;
                  bus_ready  <= 1'b1;
                end
              end
            end
          end
          OP_PIXEL: begin
            if (q_data.row_ok) begin
              frame_rows[cidx] <= q_data.pixel_on ? (frame_rows[cidx] | pmask)
                                                  : (frame_rows[cidx] & ~pmask);
              dirty_flag <= 1'b1;
            end
          end
          OP_WRROW: begin
            if (q_data.row_ok) begin
              frame_rows[cidx] <= q_data.row_value;
              dirty_flag       <= 1'b1;
            end
          end
          OP_CLEAR: begin
            for (int i = 0; i < 16; i++) begin
              frame_rows[i] <= 8'd0;
            end
            dirty_flag <= 1'b1;
          end
          OP_ENABLE: begin
            enabled_flag <= q_data.enable;
            if (q_data.enable) begin
              dirty_flag        <= 1'b1;
              refresh_countdown <= 10'd0;
              bus_ready         <= 1'b1;
            end
          end
          OP_BRIGHT: begin
            brightness_level <= q_data.brightness;
            if (enabled_flag) begin
              bus_ready <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer payload: no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= res_next;
    end
    if (q_take) begin
      step <= 3'd0;
      hdr  <= 1'b1;
      half <= 1'b0;
      case (q_data.op)
        OP_RDROW: begin
          one_kind <= KIND_ROW;
          one_data <= q_data.row_ok ? frame_rows[cidx] : 8'd0;
        end
        OP_ENABLE: begin
          one_kind <= KIND_BUS;
          one_data <= BYTE_DISP_OFF;
        end
        default: begin
          one_kind <= KIND_BUS;
          one_data <= BYTE_DIM | {4'd0, q_data.brightness};
        end
      endcase
    end else if (load) begin
      if (state == B_ENABLE) begin
        step <= step + 3'd1;
      end else if (state == B_FRAME) begin
        if (hdr) begin
          hdr <= 1'b0;
        end else begin
          // right half done: advance to next row pair
          half <= ~half;
          if (half) begin
            step <= step + 3'd1;
          end
        end
      end
    end
  end

  assign empty          = !out_valid;
  assign kind           = out_q.kind;
  assign target_address = out_q.target_address;
  assign data_byte      = out_q.data_byte;
  assign transfer_end   = out_q.transfer_end;
  assign last           = out_q.last;

  `LMFR_ASSERT_NEXT(a_last_to_idle, load && res_next.last, state == B_IDLE, "no return to idle")
  `LMFR_ASSERT_NOW(a_frame_clean, state == B_FRAME, !dirty_flag, "dirty during frame push")
  `LMFR_ASSERT_NEXT(a_load_valid, load, out_valid, "loaded result not shown")
  `LMFR_ASSERT_NOW(a_row_last, load && res_next.kind == KIND_ROW, res_next.last, "row read not last")
  `LMFR_ASSERT_NOW(a_take_idle, q_take, state == B_IDLE && !load, "command taken while busy")

endmodule

@@ verif/tb_led_matrix_frame_refresh_top.sv @@
`timescale 1ns / 1ps
module tb_led_matrix_frame_refresh_top;
  import lmfr_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int NUM_SCRIPT  = 24;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [2:0] cmd;
    logic       eye;
    logic [2:0] row;
    logic [2:0] col;
    logic       pixel_on;
    logic [7:0] row_value;
    logic       enable;
    logic [3:0] brightness;
    logic       typed;
    logic [4:0] n_res;
    logic [7:0] first_byte;
  } cmd_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  cmd = '0;
  logic        eye = 1'b0;
  logic [2:0]  row = '0;
  logic [2:0]  col = '0;
  logic        pixel_on = 1'b0;
  logic [7:0]  row_value = '0;
  logic        enable = 1'b0;
  logic [3:0]  brightness = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [6:0]  target_address;
  logic [7:0]  data_byte;
  logic        transfer_end;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_matrix_frame_refresh_top dut (.*);

  always #4 clk = ~clk;

  // Frame buffer and refresh state as the driver side should see it
  logic [7:0] frame_mem [16];
  logic       dirty_m;
  logic       enabled_m;
  logic       bus_used_m;
  logic [3:0] bright_m;
  logic [9:0] countdown_m;
  logic [9:0] refresh_cfg;
  logic [6:0] addr_cfg;

  res_t      due_results [$];
  cmd_item_t sent_items [$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  // Directed part runs on the reset configuration: refresh 20, address 113
  cmd_item_t script [NUM_SCRIPT] = '{
    // cmd        eye row col pon rval  en bri typed n  first
    '{CMD_TICK,   0, 0, 0, 0, 8'h00, 0, 0,  1, 0,  8'h00},  // disabled: no-op
    '{CMD_RDROW,  0, 0, 0, 0, 8'h00, 0, 0,  1, 1,  8'h00},  // frame cleared by reset
    '{CMD_ENABLE, 0, 0, 0, 0, 8'h00, 0, 0,  1, 0,  8'h00},  // off before bus use
    '{CMD_BRIGHT, 0, 0, 0, 0, 8'h00, 0, 15, 1, 0,  8'h00},  // stored silently
    '{CMD_WRROW,  0, 0, 0, 0, 8'hFF, 0, 0,  0, 0,  8'h00},
    '{CMD_WRROW,  1, 7, 0, 0, 8'h80, 0, 0,  0, 0,  8'h00},
    '{CMD_PIXEL,  0, 7, 7, 1, 8'h00, 0, 0,  0, 0,  8'h00},
    '{CMD_PIXEL,  1, 0, 0, 1, 8'h00, 0, 0,  0, 0,  8'h00},
    '{CMD_PIXEL,  0, 0, 3, 0, 8'h00, 0, 0,  0, 0,  8'h00},
    '{CMD_RDROW,  0, 0, 0, 0, 8'h00, 0, 0,  0, 0,  8'h00},
    '{CMD_RDROW,  1, 7, 0, 0, 8'h00, 0, 0,  0, 0,  8'h00},
    '{CMD_UNUSED, 1, 7, 7, 1, 8'hFF, 1, 15, 1, 0,  8'h00},  // unused code: drop
    '{CMD_ENABLE, 0, 0, 0, 0, 8'h00, 1, 0,  1, 3,  8'h21},
    '{CMD_TICK,   0, 0, 0, 0, 8'h00, 0, 0,  1, 17, 8'h00},  // due and dirty
    '{CMD_TICK,   0, 0, 0, 0, 8'h00, 0, 0,  1, 0,  8'h00},  // counting down
    '{CMD_BRIGHT, 0, 0, 0, 0, 8'h00, 0, 0,  1, 1,  8'hE0},
    '{CMD_ENABLE, 0, 0, 0, 0, 8'h00, 1, 0,  1, 3,  8'h21},  // enable while enabled
    '{CMD_TICK,   0, 0, 0, 0, 8'h00, 0, 0,  1, 17, 8'h00},
    '{CMD_CLEAR,  0, 0, 0, 0, 8'h00, 0, 0,  1, 0,  8'h00},
    '{CMD_RDROW,  1, 7, 0, 0, 8'h00, 0, 0,  1, 1,  8'h00},
    '{CMD_ENABLE, 0, 0, 0, 0, 8'h00, 0, 0,  1, 1,  8'h80},
    '{CMD_TICK,   0, 0, 0, 0, 8'h00, 0, 0,  1, 0,  8'h00},
    '{CMD_ENABLE, 0, 0, 0, 0, 8'h00, 0, 0,  1, 1,  8'h80},  // bus already used
    '{CMD_WRROW,  1, 3, 0, 0, 8'h5A, 0, 0,  0, 0,  8'h00}
  };

  function automatic void send_byte(input logic [7:0] data, input logic tend);
    res_t r;
    bus_used_m = 1'b1;
    r = '{KIND_BUS, addr_cfg, data, tend, 1'b0};
    due_results.push_back(r);
  endfunction

  // Apply one command to the frame state; returns how many results it adds
  function automatic int run_command(input logic [2:0] c, input logic e,
                                     input logic [2:0] r, input logic [2:0] cl,
                                     input logic pon, input logic [7:0] rval,
                                     input logic en, input logic [3:0] bri);
    int base;
    res_t res;
    logic [3:0] idx;
    base = due_results.size();
    idx = {e, r};
    case (c)
      CMD_TICK: begin
        if (enabled_m) begin
          if (countdown_m != 0) begin
            countdown_m = countdown_m - 10'd1;
          end else begin
            countdown_m = (refresh_cfg == 0) ? 10'd0 : refresh_cfg - 10'd1;
            if (dirty_m) begin
              send_byte(BYTE_FRAME_CMD, 1'b0);
              for (int i = 0; i < 8; i++) begin
                send_byte(frame_mem[i], 1'b0);
                send_byte(frame_mem[8 + i], i == 7);
              end
              dirty_m = 1'b0;
            end
          end
        end
      end
      CMD_PIXEL: begin
        frame_mem[idx][cl] = pon;
        dirty_m = 1'b1;
      end
      CMD_WRROW: begin
        frame_mem[idx] = rval;
        dirty_m = 1'b1;
      end
      CMD_RDROW: begin
        res = '{KIND_ROW, 7'd0, frame_mem[idx], 1'b0, 1'b0};
        due_results.push_back(res);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 16; i++) frame_mem[i] = 8'h00;
        dirty_m = 1'b1;
      end
      CMD_ENABLE: begin
        enabled_m = en;
        if (en) begin
          send_byte(BYTE_OSC_ON, 1'b1);
          send_byte(BYTE_DIM | {4'h0, bright_m}, 1'b1);
          send_byte(BYTE_DISP_ON, 1'b1);
          dirty_m = 1'b1;
          countdown_m = 10'd0;
        end else if (bus_used_m) begin
          send_byte(BYTE_DISP_OFF, 1'b1);
        end
      end
      CMD_BRIGHT: begin
        bright_m = bri;
        if (enabled_m) send_byte(BYTE_DIM | {4'h0, bright_m}, 1'b1);
      end
      default: ;
    endcase
    if (due_results.size() > base) begin
      res = due_results.pop_back();
      res.last = 1'b1;
      due_results.push_back(res);
    end
    return due_results.size() - base;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    res_t got, want;
    cmd_item_t item;
    int base, made;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{kind, target_address, data_byte, transfer_end, last};
        if (due_results.size() == 0) begin
          errors++;
          $error("unexpected result: data_byte %02h", data_byte);
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("target_address", want.target_address, got.target_address);
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("transfer_end", want.transfer_end, got.transfer_end);
          check_field("last", want.last, got.last);
        end
      end
      if (push && !full) begin
        item = sent_items.pop_front();
        base = due_results.size();
        made = run_command(cmd, eye, row, col, pixel_on, row_value, enable, brightness);
        if (item.typed) begin
          if (made != item.n_res) begin
            errors++;
            $error("result count: expected %0d, got %0d", item.n_res, made);
          end else if (made != 0) begin
            check_field("first data_byte", item.first_byte, due_results[base].data_byte);
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input cmd_item_t item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    sent_items.push_back(item);
    push       <= 1'b1;
    cmd        <= item.cmd;
    eye        <= item.eye;
    row        <= item.row;
    col        <= item.col;
    pixel_on   <= item.pixel_on;
    row_value  <= item.row_value;
    enable     <= item.enable;
    brightness <= item.brightness;
    do @(posedge clk); while (full);
  endtask

  // Hold off until every expected result is out and the block has gone quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_REFRESH) refresh_cfg = val[9:0];
    else addr_cfg = val[6:0];
  endtask

  // Mostly ticks and frame edits so that enabled refresh paths get exercised
  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.cmd = CMD_TICK;
    else if (pick < 50) it.cmd = CMD_PIXEL;
    else if (pick < 63) it.cmd = CMD_WRROW;
    else if (pick < 73) it.cmd = CMD_RDROW;
    else if (pick < 77) it.cmd = CMD_CLEAR;
    else if (pick < 87) it.cmd = CMD_ENABLE;
    else if (pick < 96) it.cmd = CMD_BRIGHT;
    else it.cmd = CMD_UNUSED;
    it.eye        = 1'($urandom_range(0, 1));
    it.row        = 3'($urandom_range(0, 7));
    it.col        = 3'($urandom_range(0, 7));
    it.pixel_on   = 1'($urandom_range(0, 1));
    it.row_value  = 8'($urandom_range(0, 255));
    it.enable     = $urandom_range(0, 3) != 0;
    it.brightness = 4'($urandom_range(0, 15));
    it.typed      = 1'b0;
    it.n_res      = '0;
    it.first_byte = '0;
    return it;
  endfunction

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [9:0] rms;
    logic [6:0] adr;
    int n_items;
    for (int i = 0; i < 16; i++) frame_mem[i] = 8'h00;
    dirty_m     = 1'b0;
    enabled_m   = 1'b0;
    bus_used_m  = 1'b0;
    bright_m    = BRIGHT_RESET;
    countdown_m = 10'd0;
    refresh_cfg = REFRESH_RESET;
    addr_cfg    = ADDR_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i]);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          rms = 10'd1;
          adr = 7'd0;
          n_items = 50;
        end
        1: begin
          rms = 10'd1000;
          adr = 7'd127;
          n_items = 40;
        end
        2: begin
          rms = 10'($urandom_range(2, 6));
          adr = 7'($urandom_range(0, 127));
          n_items = 50;
        end
        default: begin
          rms = 10'd3;
          adr = 7'($urandom_range(0, 127));
          n_items = 60;
          calm = 1'b1;
        end
      endcase
      reg_write(REG_REFRESH, {22'd0, rms});
      reg_write(REG_ADDR, {25'd0, adr});
      for (int k = 0; k < n_items; k++) send_item(random_item());
    end

    settle();
    if (errors == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lmfr_pkg.sv
hw/rtl/lmfr_front.sv
hw/rtl/lmfr_back.sv
hw/rtl/led_matrix_frame_refresh_top.sv
verif/tb_led_matrix_frame_refresh_top.sv
